// ===== rtl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// shared types, constants and tables for the wheel odometry block
// ----------------------------------------------------------------------------
package ddo_pkg;

  localparam int MUL_W   = 64;  // product width of the serial multiplier
  localparam int MULB_W  = 24;  // multiplier operand width
  localparam int CNT_W   = 5;   // bit counter width
  localparam int CRD_W   = 46;  // cordic datapath width
  localparam int ANG_W   = 26;  // cordic residual angle width
  localparam int ATAN_N  = 24;

  localparam logic [MULB_W-1:0] INV_GAIN_Q20   = 24'd636751;
  localparam logic [MULB_W-1:0] INV_TWO_PI_Q22 = 24'd667544;

  typedef enum logic [1:0] {
    REG_MPT = 2'd0,
    REG_IWB = 2'd1,
    REG_IIV = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

  function automatic logic signed [ANG_W-1:0] atan_lut(input logic [CNT_W-1:0] i);
    logic signed [ANG_W-1:0] v;
    unique case (i)
      5'd0:  v = 26'sd2097152;
      5'd1:  v = 26'sd1238021;
      5'd2:  v = 26'sd654136;
      5'd3:  v = 26'sd332050;
      5'd4:  v = 26'sd166669;
      5'd5:  v = 26'sd83416;
      5'd6:  v = 26'sd41718;
      5'd7:  v = 26'sd20860;
      5'd8:  v = 26'sd10430;
      5'd9:  v = 26'sd5215;
      5'd10: v = 26'sd2608;
      5'd11: v = 26'sd1304;
      5'd12: v = 26'sd652;
      5'd13: v = 26'sd326;
      5'd14: v = 26'sd163;
      5'd15: v = 26'sd81;
      5'd16: v = 26'sd41;
      5'd17: v = 26'sd20;
      5'd18: v = 26'sd10;
      5'd19: v = 26'sd5;
      5'd20: v = 26'sd3;
      5'd21: v = 26'sd1;
      5'd22: v = 26'sd1;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [MUL_W-1:0] v);
    logic signed [23:0] r;
    if (v > 64'sd8388607) begin
      r = 24'sh7fffff;
    end else if (v < -64'sd8388608) begin
      r = 24'sh800000;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ddo_in_if.sv =====
// ----------------------------------------------------------------------------
// ddo_in_if
// encoder tick channel: valid, ready and the two tick deltas
// ----------------------------------------------------------------------------
interface ddo_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_ticks;
  logic signed [15:0] right_ticks;

  modport source (output valid, left_ticks, right_ticks, input ready);
  modport sink   (input valid, left_ticks, right_ticks, output ready);
endinterface

// ===== rtl/ddo_out_if.sv =====
// ----------------------------------------------------------------------------
// ddo_out_if
// pose channel: valid, ready, pose and velocities
// ----------------------------------------------------------------------------
interface ddo_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [23:0] heading_angle;
  logic signed [23:0] linear_speed;
  logic signed [23:0] turn_rate;

  modport source (output valid, pos_x, pos_y, heading_angle, linear_speed, turn_rate,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, heading_angle, linear_speed, turn_rate,
                  output ready);
endinterface

// ===== rtl/ddo_serial_mul.sv =====
// ----------------------------------------------------------------------------
// ddo_serial_mul
// bit-serial shift-add multiplier, signed by unsigned, one bit per cycle
// ----------------------------------------------------------------------------
module ddo_serial_mul (
  input  logic                               clk,
  input  logic                               rst,
  input  ddo_pkg::mul_ctl_t                  ctl,
  input  logic signed [ddo_pkg::MUL_W-1:0]   a,
  input  logic        [ddo_pkg::MULB_W-1:0]  b,
  output logic signed [ddo_pkg::MUL_W-1:0]   p,
  output ddo_pkg::unit_stat_t                stat
);
  import ddo_pkg::*;

  logic signed [MUL_W-1:0]  a_sh;
  logic        [MULB_W-1:0] b_sh;
  logic        [CNT_W-1:0]  cnt;
  logic signed [MUL_W-1:0]  acc;
  logic                     busy;
  logic                     done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_sh <= a;
      b_sh <= b;
      cnt  <= ctl.nbits;
      acc  <= '0;
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= a_sh <<< 1;
      b_sh <= b_sh >> 1;
      cnt  <= cnt - CNT_W'(1);
    end
  end

  assign p         = acc;
  assign stat.busy = busy;
  assign stat.done = done;
endmodule

// ===== rtl/ddo_cordic.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic
// iterative rotation cordic, one micro-rotation per cycle, quadrant fold
// ----------------------------------------------------------------------------
module ddo_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [40:0]                mag,
  input  logic        [23:0]                angle,
  output logic signed [ddo_pkg::CRD_W-1:0]  ox,
  output logic signed [ddo_pkg::CRD_W-1:0]  oy,
  output ddo_pkg::unit_stat_t               stat
);
  import ddo_pkg::*;

  localparam int RUN = (CORDIC_STEPS < ATAN_N) ? CORDIC_STEPS : ATAN_N;

  logic signed [CRD_W-1:0] x;
  logic signed [CRD_W-1:0] y;
  logic signed [ANG_W-1:0] z;
  logic        [1:0]       quad;
  logic        [CNT_W-1:0] i;
  logic                    busy;
  logic                    done;
  logic signed [CRD_W-1:0] xs;
  logic signed [CRD_W-1:0] ys;

  assign xs = x >>> i;
  assign ys = y >>> i;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && i == CNT_W'(RUN - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= CRD_W'(mag);
      y    <= '0;
      z    <= ANG_W'({1'b0, angle[21:0]});
      quad <= angle[23:22];
      i    <= '0;
    end else if (busy) begin
      if (!z[ANG_W-1]) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - atan_lut(i);
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + atan_lut(i);
      end
      i <= i + CNT_W'(1);
    end
  end

  // exact quadrant rotation
  always_comb begin
    unique case (quad)
      2'd1: begin
        ox = -y;
        oy = x;
      end
      2'd2: begin
        ox = -x;
        oy = -y;
      end
      2'd3: begin
        ox = y;
        oy = -x;
      end
      default: begin
        ox = x;
        oy = y;
      end
    endcase
  end

  assign stat.busy = busy;
  assign stat.done = done;
endmodule

// ===== rtl/diff_drive_odometry_top.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry_top
// differential drive wheel odometry: pose, heading and velocity update
// ----------------------------------------------------------------------------
// sequence: an accepted input runs seven products in turn on one bit-serial
//   multiplier, each with a load step and a store step, and then a closing
//   pose update that waits for the cordic and for a free result register
// the next input is taken only once the previous item has finished; the cordic runs beside the multiplier
// the result register frees the input side while a result waits for transfer
// reset: synchronous; pose and heading clear to zero, registers load defaults
// ----------------------------------------------------------------------------
module diff_drive_odometry_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [23:0] wr_data,
  ddo_in_if.sink      odo_in,
  ddo_out_if.source   odo_out
);
  import ddo_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_RUN  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    OP_SUM  = 3'd0,
    OP_GAIN = 3'd1,
    OP_DIFF = 3'd2,
    OP_BASE = 3'd3,
    OP_TURN = 3'd4,
    OP_LIN  = 3'd5,
    OP_RATE = 3'd6
  } op_t;

  // configuration registers
  logic [23:0] mpt;
  logic [15:0] iwb;
  logic [15:0] iiv;

  always_ff @(posedge clk) begin
    if (rst) begin
      mpt <= 24'd8389;
      iwb <= 16'd27307;
      iiv <= 16'd2560;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MPT: mpt <= wr_data;
        REG_IWB: iwb <= wr_data[15:0];
        REG_IIV: iiv <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  state_t state;
  op_t    op;

  // latched wheel sum and difference of the current item
  logic signed [16:0] sum;
  logic signed [16:0] diff;

  // intermediate results
  logic signed [40:0] d24;
  logic signed [41:0] q;
  logic signed [41:0] t20;
  logic        [23:0] dturn;
  logic signed [23:0] lin;
  logic signed [23:0] rate;

  // pose state
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic        [23:0] heading;

  // result register
  logic               out_valid;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic        [23:0] out_h;
  logic signed [23:0] out_lin;
  logic signed [23:0] out_rate;

  // multiplier hookup
  mul_ctl_t                mul_ctl;
  logic signed [MUL_W-1:0] mul_a;
  logic        [MULB_W-1:0] mul_b;
  logic signed [MUL_W-1:0] mul_p;
  unit_stat_t              mul_stat;

  // operand select per product
  always_comb begin
    mul_ctl.start = (state == S_LOAD);
    unique case (op)
      OP_SUM: begin
        mul_a = MUL_W'(sum);  mul_b = mpt;                  mul_ctl.nbits = CNT_W'(24);
      end
      OP_GAIN: begin
        mul_a = MUL_W'(d24);  mul_b = INV_GAIN_Q20;         mul_ctl.nbits = CNT_W'(20);
      end
      OP_DIFF: begin
        mul_a = MUL_W'(diff); mul_b = mpt;                  mul_ctl.nbits = CNT_W'(24);
      end
      OP_BASE: begin
        mul_a = MUL_W'(q);    mul_b = MULB_W'(iwb);         mul_ctl.nbits = CNT_W'(16);
      end
      OP_TURN: begin
        mul_a = MUL_W'(t20);  mul_b = INV_TWO_PI_Q22;       mul_ctl.nbits = CNT_W'(20);
      end
      OP_LIN: begin
        mul_a = MUL_W'(d24);  mul_b = MULB_W'(iiv);         mul_ctl.nbits = CNT_W'(16);
      end
      default: begin
        mul_a = MUL_W'(t20);  mul_b = MULB_W'(iiv);         mul_ctl.nbits = CNT_W'(16);
      end
    endcase
  end

  ddo_serial_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mul_ctl),
    .a    (mul_a),
    .b    (mul_b),
    .p    (mul_p),
    .stat (mul_stat)
  );

  // rounded product views, round half up then floor shift
  logic signed [MUL_W-1:0] r1;
  logic signed [MUL_W-1:0] r16;
  logic signed [MUL_W-1:0] r18;
  logic signed [MUL_W-1:0] r20;
  logic signed [MUL_W-1:0] r12;

  assign r1  = (mul_p + 64'sd1) >>> 1;
  assign r16 = (mul_p + 64'sd32768) >>> 16;
  assign r18 = (mul_p + 64'sd131072) >>> 18;
  assign r20 = (mul_p + 64'sd524288) >>> 20;
  assign r12 = (mul_p + 64'sd2048) >>> 12;

  // cordic on the heading held before this item
  logic                    crd_start;
  logic signed [CRD_W-1:0] cx;
  logic signed [CRD_W-1:0] cy;
  unit_stat_t              crd_stat;

  assign crd_start = (state == S_RUN) && mul_stat.done && (op == OP_GAIN);

  // the scaled distance goes straight from the gain product into the cordic
  ddo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (crd_start),
    .mag   (r20[40:0]),
    .angle (heading),
    .ox    (cx),
    .oy    (cy),
    .stat  (crd_stat)
  );

  // pose update with saturation
  logic signed [CRD_W-1:0] dx_w;
  logic signed [CRD_W-1:0] dy_w;
  logic signed [CRD_W:0]   nx;
  logic signed [CRD_W:0]   ny;
  logic signed [31:0]      sx;
  logic signed [31:0]      sy;

  assign dx_w = (cx + CRD_W'(128)) >>> 8;
  assign dy_w = (cy + CRD_W'(128)) >>> 8;
  assign nx   = (CRD_W+1)'(pose_x) + (CRD_W+1)'(dx_w);
  assign ny   = (CRD_W+1)'(pose_y) + (CRD_W+1)'(dy_w);

  always_comb begin
    if (nx > (CRD_W+1)'(32'sh7fffffff)) begin
      sx = 32'sh7fffffff;
    end else if (nx < -(CRD_W+1)'(64'sh80000000)) begin
      sx = 32'sh80000000;
    end else begin
      sx = nx[31:0];
    end
    if (ny > (CRD_W+1)'(32'sh7fffffff)) begin
      sy = 32'sh7fffffff;
    end else if (ny < -(CRD_W+1)'(64'sh80000000)) begin
      sy = 32'sh80000000;
    end else begin
      sy = ny[31:0];
    end
  end

  logic fin_go;
  assign fin_go = (state == S_FIN) && !crd_stat.busy && (!out_valid || odo_out.ready);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_SUM;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (odo_in.valid) begin
            state <= S_LOAD;
            op    <= OP_SUM;
          end
        end
        S_LOAD: state <= S_RUN;
        S_RUN: begin
          if (mul_stat.done) begin
            if (op == OP_RATE) begin
              state <= S_FIN;
            end else begin
              op    <= op_t'(op + 3'd1);
              state <= S_LOAD;
            end
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // input transfer latch
  always_ff @(posedge clk) begin
    if (state == S_IDLE && odo_in.valid) begin
      sum  <= 17'(odo_in.left_ticks) + 17'(odo_in.right_ticks);
      diff <= 17'(odo_in.right_ticks) - 17'(odo_in.left_ticks);
    end
  end

  // store each product but the gain product, which feeds the cordic directly
  always_ff @(posedge clk) begin
    if (state == S_RUN && mul_stat.done) begin
      unique case (op)
        OP_SUM:  d24   <= r1[40:0];
        OP_GAIN: ;
        OP_DIFF: q     <= mul_p[41:0];
        OP_BASE: t20   <= r16[41:0];
        OP_TURN: dturn <= r18[23:0];
        OP_LIN:  lin   <= sat24(r16);
        default: rate  <= sat24(r12);
      endcase
    end
  end

  // pose state
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x  <= '0;
      pose_y  <= '0;
      heading <= '0;
    end else if (fin_go) begin
      pose_x  <= sx;
      pose_y  <= sy;
      heading <= heading + dturn;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (odo_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_x    <= sx;
      out_y    <= sy;
      out_h    <= heading + dturn;
      out_lin  <= lin;
      out_rate <= rate;
    end
  end

  assign odo_in.ready          = (state == S_IDLE);
  assign odo_out.valid         = out_valid;
  assign odo_out.pos_x         = out_x;
  assign odo_out.pos_y         = out_y;
  assign odo_out.heading_angle = out_h;
  assign odo_out.linear_speed  = out_lin;
  assign odo_out.turn_rate     = out_rate;

  // checks
  a_idle_cordic: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !crd_stat.busy)
    else $error("cordic still busy while idle");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    mul_stat.done |-> (state == S_RUN))
    else $error("multiplier finished outside run state");

  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (out_valid && odo_out.ready && !fin_go) |=> !out_valid)
    else $error("result not cleared after transfer");

  a_cordic_load: assert property (@(posedge clk) disable iff (rst)
    crd_start |=> crd_stat.busy)
    else $error("cordic did not start after load");

  a_single_unit_start: assert property (@(posedge clk) disable iff (rst)
    crd_start |-> !crd_stat.busy && !mul_stat.busy)
    else $error("cordic started while a unit is busy");
endmodule
